### rtl/prtt_pkg.sv
// prtt_pkg: sizes, codes and shared types of the pending result retransmit table
// no dependencies; imported by prtt_front, prtt_fifo, prtt_back, the top module and tb_top

package prtt_pkg;

	// table geometry
	localparam int SLOTS     = 4;
	localparam int DATA_MAX  = 8;
	localparam int HDR_BYTES = 5;

	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LEN_W     = $clog2(DATA_MAX + 1);
	localparam int BYTE_W    = $clog2(DATA_MAX + HDR_BYTES);
	localparam int OFF_W     = (DATA_MAX > 1) ? $clog2(DATA_MAX) : 1;
	localparam int PAY_DEPTH = SLOTS * DATA_MAX;
	localparam int ADDR_W    = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;

	// command queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// configuration registers
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_MAGIC = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_KIND  = 1'b1;

	// header byte positions inside a frame
	localparam logic [BYTE_W-1:0] HB_MAGIC = BYTE_W'(0);
	localparam logic [BYTE_W-1:0] HB_KIND  = BYTE_W'(1);
	localparam logic [BYTE_W-1:0] HB_ID    = BYTE_W'(2);
	localparam logic [BYTE_W-1:0] HB_TYPE  = BYTE_W'(3);
	localparam logic [BYTE_W-1:0] HB_LEN   = BYTE_W'(4);

	typedef enum logic [1:0] {
		ACT_PUSH = 2'd0,
		ACT_DATA = 2'd1,
		ACT_ACK  = 2'd2,
		ACT_PUMP = 2'd3
	} action_t;

	// classified command handed from front to back
	typedef struct packed {
		action_t            act;
		logic [7:0]         result_type;
		logic [LEN_W-1:0]   plen;
		logic [7:0]         data_byte;
		logic [7:0]         ack_id;
	} cmd_t;

	// one result word
	typedef struct packed {
		logic       byte_valid;
		logic [7:0] out_byte;
		logic       frame_end;
		logic       run_end;
		logic [7:0] assigned_id;
		logic       evicted;
		logic [7:0] evicted_id;
		logic       ack_hit;
		logic       any_pending;
	} res_t;

endpackage

### rtl/prtt_if.sv
// prtt_req_if and prtt_rsp_if: valid/ready channels for commands and result words
// no dependencies

interface prtt_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] result_type;
	logic [7:0] push_length;
	logic [7:0] data_byte;
	logic [7:0] ack_id;

	modport source (output valid, action, result_type, push_length, data_byte, ack_id,
		input ready);
	modport sink (input valid, action, result_type, push_length, data_byte, ack_id,
		output ready);
endinterface

interface prtt_rsp_if;
	logic       valid;
	logic       ready;
	logic       byte_valid;
	logic [7:0] out_byte;
	logic       frame_end;
	logic       run_end;
	logic [7:0] assigned_id;
	logic       evicted;
	logic [7:0] evicted_id;
	logic       ack_hit;
	logic       any_pending;

	modport source (output valid, byte_valid, out_byte, frame_end, run_end, assigned_id,
		evicted, evicted_id, ack_hit, any_pending, input ready);
	modport sink (input valid, byte_valid, out_byte, frame_end, run_end, assigned_id,
		evicted, evicted_id, ack_hit, any_pending, output ready);
endinterface

### rtl/prtt_ram.sv
// prtt_ram: generic single write port ram with registered read
// no dependencies

module prtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/prtt_front.sv
// prtt_front: accepts command words, decodes the action and clips the length
// depends on prtt_pkg and prtt_req_if

module prtt_front (
	input  logic           clk,
	input  logic           arst_n,
	prtt_req_if.sink       req,
	input  logic           clearing,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output prtt_pkg::cmd_t cmd
);
	import prtt_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_d;
	logic accept;

	assign req.ready = !clearing && (!valid_s1 || cmd_ready);
	assign accept    = req.valid && req.ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	// decode and length clip
	always_comb begin
		cmd_d             = '0;
		cmd_d.act         = action_t'(req.action);
		cmd_d.result_type = req.result_type;
		cmd_d.plen        = (req.push_length > 8'(DATA_MAX)) ? LEN_W'(DATA_MAX)
			: LEN_W'(req.push_length);
		cmd_d.data_byte   = req.data_byte;
		cmd_d.ack_id      = req.ack_id;
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cmd_s1   <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			cmd_s1   <= cmd_d;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

### rtl/prtt_fifo.sv
// prtt_fifo: short command queue between front and back
// depends on prtt_pkg

module prtt_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  prtt_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output prtt_pkg::cmd_t pop_data
);
	import prtt_pkg::*;

	cmd_t                q_mem [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != Q_CNT_W'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = q_mem[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/prtt_back.sv
// prtt_back: slot table, payload memory and frame streaming, one command at a time
// depends on prtt_pkg, prtt_rsp_if and prtt_ram

module prtt_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [prtt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_wdata,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  prtt_pkg::cmd_t                 cmd,
	output logic                           clearing,
	prtt_rsp_if.source                     rsp
);
	import prtt_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_EVICT,
		S_EVDONE,
		S_PUMP
	} state_t;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

	state_t              state_q;
	cmd_t                cmd_q;
	logic [SLOTS-1:0]    used_q;
	logic [7:0]          id_q   [SLOTS];
	logic [7:0]          type_q [SLOTS];
	logic [LEN_W-1:0]    len_q  [SLOTS];
	logic [7:0]          next_id_q;
	logic [SLOT_W-1:0]   wr_slot_q;
	logic [LEN_W-1:0]    wr_idx_q;
	logic [LEN_W-1:0]    wr_len_q;
	logic [SLOT_W-1:0]   sel_q;
	logic [7:0]          min_id_q;
	logic [SLOT_W-1:0]   slot_idx_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [7:0]          magic_q;
	logic [7:0]          kind_q;
	logic                out_valid_q;
	res_t                res_q;

	logic                out_free;
	logic                free_hit;
	logic [SLOT_W-1:0]   free_slot;
	logic                match_hit;
	logic [SLOT_W-1:0]   match_slot;
	logic [SLOTS-1:0]    used_after_ack;
	logic                first_hit;
	logic [SLOT_W-1:0]   first_slot;
	logic                nxt_hit;
	logic [SLOT_W-1:0]   nxt_slot;
	logic [LEN_W-1:0]    cur_len;
	logic                frame_last;
	logic [7:0]          pump_byte;
	logic                pump_ld;
	logic [SLOT_W-1:0]   slot_nx;
	logic [BYTE_W-1:0]   byte_nx;
	logic [SLOT_W-1:0]   ra_slot;
	logic [BYTE_W-1:0]   ra_byte;
	logic [OFF_W-1:0]    ra_off;
	logic                push_do;
	logic [SLOT_W-1:0]   push_slot;
	logic                push_ev;
	logic [7:0]          nid_inc;
	logic                data_wr;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [7:0]          ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [7:0]          ram_rdata;
	logic                res_ld;
	res_t                res_d;

	function automatic logic [ADDR_W-1:0] pay_addr(input logic [SLOT_W-1:0] s,
		input logic [OFF_W-1:0] o);
		return ADDR_W'(s) * ADDR_W'(DATA_MAX) + ADDR_W'(o);
	endfunction

	assign out_free  = !out_valid_q || rsp.ready;
	assign cmd_ready = (state_q == S_IDLE);
	assign clearing  = (state_q == S_CLEAR);

	// free slot, ack match, first used and next used slot
	always_comb begin
		free_hit   = 1'b0;
		free_slot  = '0;
		match_hit  = 1'b0;
		match_slot = '0;
		first_hit  = 1'b0;
		first_slot = '0;
		nxt_hit    = 1'b0;
		nxt_slot   = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!used_q[i] && !free_hit) begin
				free_hit  = 1'b1;
				free_slot = SLOT_W'(i);
			end
			if (used_q[i] && (id_q[i] == cmd_q.ack_id) && !match_hit) begin
				match_hit  = 1'b1;
				match_slot = SLOT_W'(i);
			end
			if (used_q[i] && !first_hit) begin
				first_hit  = 1'b1;
				first_slot = SLOT_W'(i);
			end
			if (used_q[i] && (SLOT_W'(i) > slot_idx_q) && !nxt_hit) begin
				nxt_hit  = 1'b1;
				nxt_slot = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		used_after_ack = used_q;
		if (match_hit) begin
			used_after_ack[match_slot] = 1'b0;
		end
	end

	// current frame byte and next stream position
	assign cur_len    = len_q[slot_idx_q];
	assign frame_last = (byte_q == BYTE_W'(cur_len) + BYTE_W'(HDR_BYTES - 1));
	assign pump_ld    = (state_q == S_PUMP) && out_free;
	assign slot_nx    = frame_last ? nxt_slot : slot_idx_q;
	assign byte_nx    = frame_last ? '0 : byte_q + 1'b1;

	always_comb begin
		case (byte_q)
			HB_MAGIC: pump_byte = magic_q;
			HB_KIND:  pump_byte = kind_q;
			HB_ID:    pump_byte = id_q[slot_idx_q];
			HB_TYPE:  pump_byte = type_q[slot_idx_q];
			HB_LEN:   pump_byte = 8'(cur_len);
			default:  pump_byte = ram_rdata;
		endcase
	end

	// read address follows the position that shows next cycle
	assign ra_slot   = pump_ld ? slot_nx : slot_idx_q;
	assign ra_byte   = pump_ld ? byte_nx : byte_q;
	assign ra_off    = (ra_byte >= BYTE_W'(HDR_BYTES))
		? OFF_W'(ra_byte - BYTE_W'(HDR_BYTES)) : '0;
	assign ram_raddr = pay_addr(ra_slot, ra_off);

	// push into a free slot or into the evicted one
	assign push_ev   = (state_q == S_EVDONE);
	assign push_slot = push_ev ? sel_q : free_slot;
	assign push_do   = out_free && (push_ev
		|| ((state_q == S_EXEC) && (cmd_q.act == ACT_PUSH) && free_hit));
	assign nid_inc   = next_id_q + 8'd1;

	// payload write and clearing pass
	assign data_wr   = (state_q == S_EXEC) && (cmd_q.act == ACT_DATA) && out_free
		&& (wr_idx_q < wr_len_q);
	assign ram_we    = clearing || data_wr;
	assign ram_waddr = clearing ? clr_q : pay_addr(wr_slot_q, OFF_W'(wr_idx_q));
	assign ram_wdata = clearing ? 8'd0 : cmd_q.data_byte;

	prtt_ram #(
		.WIDTH (8),
		.DEPTH (PAY_DEPTH)
	) u_pay_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result word for this cycle
	always_comb begin
		res_ld = 1'b0;
		res_d  = '0;
		if (push_do) begin
			res_ld            = 1'b1;
			res_d.run_end     = 1'b1;
			res_d.assigned_id = next_id_q;
			res_d.evicted     = push_ev;
			res_d.evicted_id  = push_ev ? min_id_q : 8'd0;
			res_d.any_pending = 1'b1;
		end else if (pump_ld) begin
			res_ld            = 1'b1;
			res_d.byte_valid  = 1'b1;
			res_d.out_byte    = pump_byte;
			res_d.frame_end   = frame_last;
			res_d.run_end     = frame_last && !nxt_hit;
			res_d.any_pending = 1'b1;
		end else if ((state_q == S_EXEC) && out_free) begin
			case (cmd_q.act)
				ACT_DATA: begin
					res_ld            = 1'b1;
					res_d.run_end     = 1'b1;
					res_d.any_pending = |used_q;
				end
				ACT_ACK: begin
					res_ld            = 1'b1;
					res_d.run_end     = 1'b1;
					res_d.ack_hit     = match_hit;
					res_d.any_pending = |used_after_ack;
				end
				ACT_PUMP: begin
					res_ld        = !first_hit;
					res_d.run_end = 1'b1;
				end
				default: begin
					res_ld = 1'b0;
				end
			endcase
		end
	end

	// sequencer, table state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cmd_q       <= '0;
			used_q      <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				id_q[i]   <= '0;
				type_q[i] <= '0;
				len_q[i]  <= '0;
			end
			next_id_q   <= 8'd1;
			wr_slot_q   <= '0;
			wr_idx_q    <= '0;
			wr_len_q    <= '0;
			sel_q       <= '0;
			min_id_q    <= '0;
			slot_idx_q  <= '0;
			byte_q      <= '0;
			clr_q       <= '0;
			magic_q     <= '0;
			kind_q      <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_MAGIC: magic_q <= cfg_wdata;
					REG_FRAME_KIND:  kind_q  <= cfg_wdata;
					default: ;
				endcase
			end

			// output register
			if (res_ld) begin
				out_valid_q <= 1'b1;
				res_q       <= res_d;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			// slot fill on push
			if (push_do) begin
				used_q[push_slot] <= 1'b1;
				id_q[push_slot]   <= next_id_q;
				type_q[push_slot] <= cmd_q.result_type;
				len_q[push_slot]  <= cmd_q.plen;
				next_id_q         <= (nid_inc == 8'd0) ? 8'd1 : nid_inc;
				wr_slot_q         <= push_slot;
				wr_idx_q          <= '0;
				wr_len_q          <= cmd_q.plen;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(PAY_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (cmd_q.act)
						ACT_PUSH: begin
							if (free_hit) begin
								if (out_free) begin
									state_q <= S_IDLE;
								end
							end else begin
								sel_q    <= '0;
								min_id_q <= id_q[0];
								if (SLOTS == 1) begin
									state_q <= S_EVDONE;
								end else begin
									slot_idx_q <= SLOT_W'(1);
									state_q    <= S_EVICT;
								end
							end
						end
						ACT_DATA: begin
							if (out_free) begin
								if (data_wr) begin
									wr_idx_q <= wr_idx_q + 1'b1;
								end
								state_q <= S_IDLE;
							end
						end
						ACT_ACK: begin
							if (out_free) begin
								used_q  <= used_after_ack;
								state_q <= S_IDLE;
							end
						end
						ACT_PUMP: begin
							if (first_hit) begin
								slot_idx_q <= first_slot;
								byte_q     <= '0;
								state_q    <= S_PUMP;
							end else if (out_free) begin
								state_q <= S_IDLE;
							end
						end
					endcase
				end
				S_EVICT: begin
					// smallest raw id wins, lowest slot on a tie
					if (id_q[slot_idx_q] < min_id_q) begin
						sel_q    <= slot_idx_q;
						min_id_q <= id_q[slot_idx_q];
					end
					if (slot_idx_q == SLOT_LAST) begin
						state_q <= S_EVDONE;
					end else begin
						slot_idx_q <= slot_idx_q + 1'b1;
					end
				end
				S_EVDONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_PUMP: begin
					if (out_free) begin
						slot_idx_q <= slot_nx;
						byte_q     <= byte_nx;
						if (frame_last && !nxt_hit) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result channel
	assign rsp.valid       = out_valid_q;
	assign rsp.byte_valid  = res_q.byte_valid;
	assign rsp.out_byte    = res_q.out_byte;
	assign rsp.frame_end   = res_q.frame_end;
	assign rsp.run_end     = res_q.run_end;
	assign rsp.assigned_id = res_q.assigned_id;
	assign rsp.evicted     = res_q.evicted;
	assign rsp.evicted_id  = res_q.evicted_id;
	assign rsp.ack_hit     = res_q.ack_hit;
	assign rsp.any_pending = res_q.any_pending;

endmodule

### rtl/pending_result_retransmit_table.sv
// A command word passes the front stage register and the queue, then cmd_q in the back
// end, and its result word is registered in res_q; a pump with frames goes via S_PUMP.
// The back end takes a new command only in S_IDLE; a push into a full table first runs
// the smallest-id scan through S_EVICT and S_EVDONE.
// A pump streams one byte per cycle while the result channel takes them, 5 + length
// bytes for each used slot. Reset: all control state clears at once; then the payload
// memory is zeroed one entry a cycle (SLOTS*DATA_MAX = 32 entries) with req.ready low.

module pending_result_retransmit_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [prtt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_wdata,
	prtt_req_if.sink                       req,
	prtt_rsp_if.source                     rsp
);
	import prtt_pkg::*;

	logic front_valid;
	logic front_ready;
	cmd_t front_cmd;
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;
	logic clearing;

	// accept and classify
	prtt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.clearing  (clearing),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	// decoupling queue
	prtt_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_cmd)
	);

	// table and frame streaming
	prtt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.clearing  (clearing),
		.rsp       (rsp)
	);

endmodule

### rtl/prtt_checker.sv
// prtt_checker: port level checks on the result channel of the table
// bound to pending_result_retransmit_table; no package dependency

module prtt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       byte_valid,
	input logic [7:0] out_byte,
	input logic       frame_end,
	input logic       run_end,
	input logic [7:0] assigned_id,
	input logic       evicted,
	input logic       ack_hit,
	input logic       any_pending
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(run_end)
			&& $stable(byte_valid))
		else $error("result word changed while stalled");

	// frame bytes only come while something is pending and carry no status
	a_pump_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && byte_valid |-> any_pending && assigned_id == 8'd0 && !ack_hit)
		else $error("frame byte with status bits set");

	// a status word ends its run and carries no frame byte
	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !byte_valid |-> run_end && !frame_end && out_byte == 8'd0)
		else $error("status word malformed");

	// a pump run ends on a frame boundary
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && byte_valid && run_end |-> frame_end)
		else $error("pump run ended inside a frame");

	// an eviction always comes with a fresh id
	a_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && evicted |-> assigned_id != 8'd0 && any_pending)
		else $error("eviction without assigned id");

endmodule

bind pending_result_retransmit_table prtt_checker u_prtt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.byte_valid  (rsp.byte_valid),
	.out_byte    (rsp.out_byte),
	.frame_end   (rsp.frame_end),
	.run_end     (rsp.run_end),
	.assigned_id (rsp.assigned_id),
	.evicted     (rsp.evicted),
	.ack_hit     (rsp.ack_hit),
	.any_pending (rsp.any_pending)
);

### tb/tb_top.sv
// tb_top: self-checking bench for the pending result retransmit table
// needs prtt_pkg, the prtt_req_if / prtt_rsp_if channels and the block itself
// a behavioral table model predicts every result word; a checker compares them

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import prtt_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_wdata;

	prtt_req_if req_ch ();
	prtt_rsp_if rsp_ch ();

	pending_result_retransmit_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// table model state
	logic             tbl_used    [SLOTS];
	logic [7:0]       tbl_id      [SLOTS];
	logic [7:0]       tbl_type    [SLOTS];
	logic [LEN_W-1:0] tbl_len     [SLOTS];
	logic [7:0]       tbl_payload [PAY_DEPTH];
	logic [7:0]       tbl_next_id;
	int               tbl_wr_slot;
	int               tbl_wr_idx;
	logic [7:0]       hdr_magic;
	logic [7:0]       hdr_kind;

	// result words still to come, oldest first
	res_t due_words [$];

	int n_errors     = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_left    = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic void clear_table_model;
		int s, a;
		for (s = 0; s < SLOTS; s++) begin
			tbl_used[s] = 1'b0;
			tbl_id[s]   = '0;
			tbl_type[s] = '0;
			tbl_len[s]  = '0;
		end
		for (a = 0; a < PAY_DEPTH; a++)
			tbl_payload[a] = '0;
		tbl_next_id = 8'd1;
		tbl_wr_slot = 0;
		tbl_wr_idx  = 0;
		hdr_magic   = '0;
		hdr_kind    = '0;
	endfunction

	function automatic logic table_busy;
		int s;
		table_busy = 1'b0;
		for (s = 0; s < SLOTS; s++)
			if (tbl_used[s])
				table_busy = 1'b1;
	endfunction

	// advance the table model by one command and queue the words it yields
	function automatic void advance_table(input action_t act, input logic [7:0] rtype,
			input logic [7:0] plen, input logic [7:0] dbyte, input logic [7:0] aid);
		res_t w;
		int   s, b, sel, total, n_bytes, n_done;
		w = '0;
		w.run_end = 1'b1;
		case (act)
			ACT_PUSH: begin
				sel = SLOTS;
				for (s = 0; s < SLOTS; s++)
					if (!tbl_used[s] && sel == SLOTS)
						sel = s;
				// full table: smallest raw id goes, lowest index on a tie
				if (sel == SLOTS) begin
					sel = 0;
					for (s = 1; s < SLOTS; s++)
						if (tbl_id[s] < tbl_id[sel])
							sel = s;
					w.evicted    = 1'b1;
					w.evicted_id = tbl_id[sel];
				end
				w.assigned_id = tbl_next_id;
				tbl_next_id++;
				if (tbl_next_id == 8'd0)
					tbl_next_id = 8'd1;
				tbl_used[sel] = 1'b1;
				tbl_id[sel]   = w.assigned_id;
				tbl_type[sel] = rtype;
				tbl_len[sel]  = (plen > DATA_MAX) ? LEN_W'(DATA_MAX) : LEN_W'(plen);
				tbl_wr_slot   = sel;
				tbl_wr_idx    = 0;
				w.any_pending = 1'b1;
				due_words.push_back(w);
			end
			ACT_DATA: begin
				// bytes past the pushed length are dropped
				if (tbl_wr_idx < tbl_len[tbl_wr_slot]) begin
					tbl_payload[tbl_wr_slot * DATA_MAX + tbl_wr_idx] = dbyte;
					tbl_wr_idx++;
				end
				w.any_pending = table_busy();
				due_words.push_back(w);
			end
			ACT_ACK: begin
				for (s = 0; s < SLOTS; s++)
					if (!w.ack_hit && tbl_used[s] && tbl_id[s] == aid) begin
						tbl_used[s] = 1'b0;
						w.ack_hit   = 1'b1;
					end
				w.any_pending = table_busy();
				due_words.push_back(w);
			end
			default: begin
				n_bytes = 0;
				for (s = 0; s < SLOTS; s++)
					if (tbl_used[s])
						n_bytes += HDR_BYTES + tbl_len[s];
				if (n_bytes == 0) begin
					due_words.push_back(w);
				end else begin
					n_done = 0;
					for (s = 0; s < SLOTS; s++) begin
						if (tbl_used[s]) begin
							total = HDR_BYTES + tbl_len[s];
							for (b = 0; b < total; b++) begin
								w = '0;
								w.byte_valid  = 1'b1;
								w.any_pending = 1'b1;
								if (b == HB_MAGIC)
									w.out_byte = hdr_magic;
								else if (b == HB_KIND)
									w.out_byte = hdr_kind;
								else if (b == HB_ID)
									w.out_byte = tbl_id[s];
								else if (b == HB_TYPE)
									w.out_byte = tbl_type[s];
								else if (b == HB_LEN)
									w.out_byte = 8'(tbl_len[s]);
								else
									w.out_byte = tbl_payload[s * DATA_MAX + b - HDR_BYTES];
								w.frame_end = (b == total - 1);
								n_done++;
								w.run_end = (n_done == n_bytes);
								due_words.push_back(w);
							end
						end
					end
				end
			end
		endcase
	endfunction

	// offer one command word, idling first at the current sender rate
	task automatic send_word(input action_t act, input logic [7:0] rtype,
			input logic [7:0] plen, input logic [7:0] dbyte, input logic [7:0] aid);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.action      <= act;
		req_ch.result_type <= rtype;
		req_ch.push_length <= plen;
		req_ch.data_byte   <= dbyte;
		req_ch.ack_id      <= aid;
		advance_table(act, rtype, plen, dbyte, aid);
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// stop offering and wait for every outstanding result word
	task automatic settle_table;
		int waited;
		waited = 0;
		req_ch.valid <= 1'b0;
		while (due_words.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
	endtask

	// both header registers, on back-to-back edges
	task automatic set_frame_header(input logic [7:0] magic, input logic [7:0] kind);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FRAME_MAGIC;
		cfg_wdata <= magic;
		@(posedge clk);
		cfg_index <= REG_FRAME_KIND;
		cfg_wdata <= kind;
		@(posedge clk);
		cfg_we    <= 1'b0;
		hdr_magic = magic;
		hdr_kind  = kind;
	endtask

	// commands against an empty table
	task automatic test_empty_table;
		send_word(ACT_PUMP, 8'h00, 8'h00, 8'h00, 8'h00);
		send_word(ACT_DATA, 8'h00, 8'h00, 8'hAA, 8'h00);
		send_word(ACT_ACK, 8'h00, 8'h00, 8'h00, 8'h00);
	endtask

	// zero and clipped lengths, payload edges, overrun byte
	task automatic test_push_and_payload;
		send_word(ACT_PUSH, 8'h00, 8'h00, 8'h00, 8'h00);
		send_word(ACT_DATA, 8'hFF, 8'hFF, 8'h55, 8'hFF);
		send_word(ACT_PUSH, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_word(ACT_DATA, 8'h00, 8'h00, 8'hFF, 8'h00);
		send_word(ACT_DATA, 8'h00, 8'h00, 8'h00, 8'h00);
		send_word(ACT_DATA, 8'h00, 8'h00, 8'hA5, 8'h00);
		send_word(ACT_DATA, 8'h00, 8'h00, 8'h5A, 8'h00);
		repeat (4)
			send_word(ACT_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		send_word(ACT_DATA, 8'h00, 8'h00, 8'h3C, 8'h00);
		send_word(ACT_PUMP, 8'h00, 8'h00, 8'h00, 8'h00);
	endtask

	// full table eviction, hits and misses, byte into an acknowledged slot
	task automatic test_evict_and_ack;
		send_word(ACT_PUSH, 8'h3C, 8'd3, 8'h00, 8'h00);
		send_word(ACT_PUSH, 8'hC3, 8'd8, 8'h00, 8'h00);
		send_word(ACT_PUSH, 8'h81, 8'd1, 8'h00, 8'h00);
		send_word(ACT_ACK, 8'h00, 8'h00, 8'h00, 8'd4);
		send_word(ACT_DATA, 8'h00, 8'h00, 8'h77, 8'h00);
		send_word(ACT_PUSH, 8'h7E, 8'd2, 8'h00, 8'h00);
		send_word(ACT_ACK, 8'h00, 8'h00, 8'h00, 8'd6);
		send_word(ACT_DATA, 8'h00, 8'h00, 8'h99, 8'h00);
		send_word(ACT_ACK, 8'h00, 8'h00, 8'h00, 8'hFF);
		send_word(ACT_PUMP, 8'h00, 8'h00, 8'h00, 8'h00);
	endtask

	// mostly well-formed push/payload runs, acks of live ids, pumps and noise
	task automatic run_random_traffic(input int n_items);
		int         sent, pick, len, k, n_live;
		logic [7:0] live_ids [SLOTS];
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, DATA_MAX);
				send_word(ACT_PUSH, 8'($urandom), 8'(len), 8'($urandom), 8'($urandom));
				sent++;
				// payload run, now and then cut short or one too long
				k = (len > DATA_MAX) ? DATA_MAX : len;
				if ($urandom_range(0, 9) == 0)
					k = $urandom_range(0, k);
				else if ($urandom_range(0, 9) == 0)
					k++;
				repeat (k) begin
					send_word(ACT_DATA, 8'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom));
					sent++;
				end
			end else if (pick < 65) begin
				n_live = 0;
				for (int s = 0; s < SLOTS; s++)
					if (tbl_used[s]) begin
						live_ids[n_live] = tbl_id[s];
						n_live++;
					end
				if (n_live > 0 && $urandom_range(0, 3) != 0)
					send_word(ACT_ACK, 8'($urandom), 8'($urandom), 8'($urandom),
						live_ids[$urandom_range(0, n_live - 1)]);
				else
					send_word(ACT_ACK, 8'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom));
				sent++;
			end else if (pick < 80) begin
				send_word(ACT_PUMP, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				sent++;
			end else begin
				send_word(action_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom));
				sent++;
			end
		end
	endtask

	// receiver holds off while full-size frames keep coming
	task automatic test_stalled_receiver;
		src_idle_pct = 0;
		hold_left = 400;
		repeat (SLOTS) begin
			send_word(ACT_PUSH, 8'($urandom), 8'(DATA_MAX), 8'($urandom), 8'($urandom));
			repeat (DATA_MAX)
				send_word(ACT_DATA, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom));
		end
		repeat (4)
			send_word(ACT_PUMP, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// result side ready, with a counted hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
			end
		end
	end

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_errors++;
		end
	endfunction

	// compare each accepted result word with the oldest prediction
	always @(posedge clk) begin : word_check
		res_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_words.size() == 0) begin
				$error("result word with nothing expected");
				n_errors++;
			end else begin
				want = due_words.pop_front();
				check_field("byte_valid", want.byte_valid, rsp_ch.byte_valid);
				check_field("out_byte", want.out_byte, rsp_ch.out_byte);
				check_field("frame_end", want.frame_end, rsp_ch.frame_end);
				check_field("run_end", want.run_end, rsp_ch.run_end);
				check_field("assigned_id", want.assigned_id, rsp_ch.assigned_id);
				check_field("evicted", want.evicted, rsp_ch.evicted);
				check_field("evicted_id", want.evicted_id, rsp_ch.evicted_id);
				check_field("ack_hit", want.ack_hit, rsp_ch.ack_hit);
				check_field("any_pending", want.any_pending, rsp_ch.any_pending);
			end
		end
	end

	// test sequence
	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_wdata          = '0;
		req_ch.valid       = 1'b0;
		req_ch.action      = ACT_PUSH;
		req_ch.result_type = '0;
		req_ch.push_length = '0;
		req_ch.data_byte   = '0;
		req_ch.ack_id      = '0;
		clear_table_model();
		src_idle_pct = 11;
		snk_idle_pct = 56;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_push_and_payload();
		settle_table();
		set_frame_header(8'hFF, 8'h00);
		test_evict_and_ack();
		run_random_traffic(12);
		settle_table();

		set_frame_header(8'h00, 8'hFF);
		src_idle_pct = 56;
		snk_idle_pct = 11;
		run_random_traffic(12);
		settle_table();

		set_frame_header(8'($urandom), 8'($urandom));
		src_idle_pct = 0;
		snk_idle_pct = 0;
		run_random_traffic(11);
		settle_table();

		set_frame_header(8'hA5, 8'h5A);
		test_stalled_receiver();
		settle_table();

		if (due_words.size() != 0) begin
			$error("%0d result words never arrived", due_words.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
